>>> rtl/isq_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// isq_pkg
// Shared constants and types for the image slice statistics block.
// ----------------------------------------------------------------------------
package isq_pkg;

    localparam int PIXEL_BITS = 16;
    localparam int MAX_PIXELS = 1048576;
    localparam int COUNT_W    = 21;
    localparam int SUM_W      = 37;
    localparam int SUMSQ_W    = 51;
    localparam int SQ_W       = 31;
    localparam int VAR_W      = 31;
    localparam int ROOT_W     = 16;
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = 2;

    localparam logic signed [PIXEL_BITS-1:0] PIX_MAX = {1'b0, {(PIXEL_BITS-1){1'b1}}};
    localparam logic signed [PIXEL_BITS-1:0] PIX_MIN = {1'b1, {(PIXEL_BITS-1){1'b0}}};
    localparam logic [COUNT_W-1:0] COUNT_LIMIT = COUNT_W'(MAX_PIXELS);

    // Accumulator snapshot taken at the end of a slice.
    typedef struct packed {
        logic signed [PIXEL_BITS-1:0] min_v;
        logic signed [PIXEL_BITS-1:0] max_v;
        logic signed [SUM_W-1:0]      sum;
        logic [SUMSQ_W-1:0]           sum_sq;
        logic [COUNT_W-1:0]           count;
    } t_snap;

    // One result item.
    typedef struct packed {
        logic [COUNT_W-1:0]           pixel_count;
        logic [ROOT_W-1:0]            std_dev;
        logic [VAR_W-1:0]             variance;
        logic [ROOT_W-1:0]            rms_value;
        logic signed [PIXEL_BITS-1:0] mean_value;
        logic signed [PIXEL_BITS-1:0] max_value;
        logic signed [PIXEL_BITS-1:0] min_value;
    } t_result;

    typedef struct packed {
        logic push;
        logic pop;
    } t_fifo_ctrl;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_DIV_MEAN,
        BK_DIV_MSQ,
        BK_SQUARE,
        BK_VAR,
        BK_SQRT_RMS,
        BK_SQRT_STD,
        BK_DONE
    } t_back_state;

endpackage
`default_nettype wire

>>> rtl/isq_fifo.sv
`default_nettype none
// ----------------------------------------------------------------------------
// isq_fifo
// Short queue of slice snapshots between the accumulator and the math unit.
// ----------------------------------------------------------------------------
module isq_fifo (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire isq_pkg::t_fifo_ctrl i_ctrl,
    input  wire isq_pkg::t_snap     i_data,
    output isq_pkg::t_snap          o_data,
    output logic                    o_empty,
    output logic [isq_pkg::FIFO_AW:0] o_level
);
    import isq_pkg::*;

    t_snap              mem [FIFO_DEPTH];
    t_snap              r_rd_data;
    logic [FIFO_AW-1:0] r_wr_ptr;
    logic [FIFO_AW-1:0] r_rd_ptr;
    logic [FIFO_AW-1:0] rd_addr;
    logic [FIFO_AW:0]   r_level;
    logic               do_push;
    logic               do_pop;

    assign do_push = i_ctrl.push && (r_level != (FIFO_AW+1)'(FIFO_DEPTH));
    assign do_pop  = i_ctrl.pop && (r_level != '0);

    // The head register follows the entry that sits at the head after this edge.
    assign rd_addr = do_pop ? r_rd_ptr + FIFO_AW'(1) : r_rd_ptr;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            mem[r_wr_ptr] <= i_data;
        end
        if (do_push && (rd_addr == r_wr_ptr)) begin
            r_rd_data <= i_data;
        end else begin
            r_rd_data <= mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_level  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + FIFO_AW'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + FIFO_AW'(1);
            end
            if (do_push && !do_pop) begin
                r_level <= r_level + (FIFO_AW+1)'(1);
            end else if (do_pop && !do_push) begin
                r_level <= r_level - (FIFO_AW+1)'(1);
            end
        end
    end

    assign o_data  = r_rd_data;
    assign o_empty = (r_level == '0);
    assign o_level = r_level;

endmodule
`default_nettype wire

>>> rtl/isq_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// isq_front
// Pixel accumulator: squares each pixel, then updates min, max, sum, sum of
// squares and count; pushes a snapshot on the last pixel of a slice.
// ----------------------------------------------------------------------------
module isq_front (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_accept,
    input  wire logic signed [isq_pkg::PIXEL_BITS-1:0] i_pixel,
    input  wire logic                             i_last,
    output logic                                  o_push,
    output isq_pkg::t_snap                        o_snap
);
    import isq_pkg::*;

    // Stage 1: pixel and its square.
    logic                         r_s1_valid;
    logic signed [PIXEL_BITS-1:0] r_s1_px;
    logic [SQ_W-1:0]              r_s1_sq;
    logic                         r_s1_last;

    // Stage 2: accumulators.
    logic signed [PIXEL_BITS-1:0] r_min, n_min;
    logic signed [PIXEL_BITS-1:0] r_max, n_max;
    logic signed [SUM_W-1:0]      r_sum, n_sum;
    logic [SUMSQ_W-1:0]           r_sum_sq, n_sum_sq;
    logic [COUNT_W-1:0]           r_count, n_count;
    logic                         take;
    logic [SQ_W-1:0]              sq_full;

    // A square never exceeds 2^30, so 31 bits hold it.
    assign sq_full = SQ_W'(i_pixel) * SQ_W'(i_pixel);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= i_accept;
        end
        r_s1_px   <= i_pixel;
        r_s1_sq   <= sq_full;
        r_s1_last <= i_last;
    end

    // Pixels beyond the slice limit are dropped; the last flag still closes.
    always_comb begin
        take     = (r_count < COUNT_LIMIT);
        n_min    = r_min;
        n_max    = r_max;
        n_sum    = r_sum;
        n_sum_sq = r_sum_sq;
        n_count  = r_count;
        if (take) begin
            if (r_s1_px < r_min) begin
                n_min = r_s1_px;
            end
            if (r_s1_px > r_max) begin
                n_max = r_s1_px;
            end
            n_sum    = r_sum + SUM_W'(r_s1_px);
            n_sum_sq = r_sum_sq + SUMSQ_W'(r_s1_sq);
            n_count  = r_count + COUNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min    <= PIX_MAX;
            r_max    <= PIX_MIN;
            r_sum    <= '0;
            r_sum_sq <= '0;
            r_count  <= '0;
        end else if (r_s1_valid) begin
            if (r_s1_last) begin
                r_min    <= PIX_MAX;
                r_max    <= PIX_MIN;
                r_sum    <= '0;
                r_sum_sq <= '0;
                r_count  <= '0;
            end else begin
                r_min    <= n_min;
                r_max    <= n_max;
                r_sum    <= n_sum;
                r_sum_sq <= n_sum_sq;
                r_count  <= n_count;
            end
        end
    end

    assign o_push        = r_s1_valid && r_s1_last;
    assign o_snap.min_v  = n_min;
    assign o_snap.max_v  = n_max;
    assign o_snap.sum    = n_sum;
    assign o_snap.sum_sq = n_sum_sq;
    assign o_snap.count  = n_count;

endmodule
`default_nettype wire

>>> rtl/isq_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// isq_back
// Statistics engine: one bit-serial divider and one bit-pair square root unit,
// each used twice per slice, followed by the result register.
// ----------------------------------------------------------------------------
module isq_back (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire isq_pkg::t_snap  i_snap,
    input  wire logic            i_empty,
    output logic                 o_pop,
    output isq_pkg::t_result     o_result,
    output logic                 o_valid,
    input  wire logic            i_ready
);
    import isq_pkg::*;

    localparam int DIV_STEPS  = SUMSQ_W;
    localparam int SQRT_STEPS = ROOT_W;
    localparam int STEP_W     = $clog2(DIV_STEPS);
    localparam int REM_W      = COUNT_W;
    localparam int SREM_W     = ROOT_W + 1;
    localparam int MAG_W      = PIXEL_BITS + 1;

    t_back_state r_state, n_state;

    logic                         r_sum_neg;
    logic signed [PIXEL_BITS-1:0] r_min, r_max;
    logic [SUMSQ_W-1:0]           r_sum_sq;
    logic [COUNT_W-1:0]           r_count;
    logic [STEP_W-1:0]            r_step;

    // Divider.
    logic [SUMSQ_W-1:0] r_dq, n_dq;
    logic [REM_W-1:0]   r_rem, n_rem;
    logic [REM_W:0]     rem_sh;
    logic               div_ge;

    // Square root.
    logic [2*ROOT_W-1:0] r_sq_val;
    logic [SREM_W-1:0]   r_sq_rem, n_sq_rem;
    logic [ROOT_W-1:0]   r_root, n_root;
    logic [SREM_W+1:0]   srem_sh;
    logic [ROOT_W+1:0]   trial;
    logic                sq_ge;

    logic [MAG_W-1:0]    r_mean_mag;
    logic [SQ_W-1:0]     r_msq;
    logic [SQ_W-1:0]     r_mean_sq;
    logic [SQ_W-1:0]     mean_prod;
    logic [VAR_W-1:0]    r_var;
    logic [ROOT_W-1:0]   r_rms;
    logic [ROOT_W-1:0]   r_std;
    logic [MAG_W-1:0]    mean_signed;
    logic [SUM_W-1:0]    sum_abs;

    logic                last_div;
    logic                last_sqrt;
    logic                load_out;

    t_result r_res;
    logic    r_out_valid;

    // Restoring division step.
    always_comb begin
        rem_sh = {r_rem, r_dq[SUMSQ_W-1]};
        div_ge = (rem_sh >= {1'b0, r_count});
        n_rem  = div_ge ? REM_W'(rem_sh - {1'b0, r_count}) : rem_sh[REM_W-1:0];
        n_dq   = {r_dq[SUMSQ_W-2:0], div_ge};
    end

    // Square root step, two radicand bits at a time.
    always_comb begin
        srem_sh  = {r_sq_rem, r_sq_val[2*ROOT_W-1 -: 2]};
        trial    = {r_root, 2'b01};
        sq_ge    = (srem_sh >= {1'b0, trial});
        n_sq_rem = sq_ge ? SREM_W'(srem_sh - {1'b0, trial}) : srem_sh[SREM_W-1:0];
        n_root   = {r_root[ROOT_W-2:0], sq_ge};
    end

    assign last_div   = (r_step == STEP_W'(DIV_STEPS - 1));
    assign last_sqrt  = (r_step == STEP_W'(SQRT_STEPS - 1));
    // The mean magnitude is at most 32768, so its square fits in 31 bits.
    assign mean_prod  = SQ_W'(r_mean_mag) * SQ_W'(r_mean_mag);
    assign sum_abs    = i_snap.sum[SUM_W-1] ? SUM_W'(-i_snap.sum) : SUM_W'(i_snap.sum);
    assign mean_signed = r_sum_neg ? MAG_W'(-r_mean_mag) : r_mean_mag;

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            BK_IDLE:     if (!i_empty)  n_state = BK_DIV_MEAN;
            BK_DIV_MEAN: if (last_div)  n_state = BK_DIV_MSQ;
            BK_DIV_MSQ:  if (last_div)  n_state = BK_SQUARE;
            BK_SQUARE:   n_state = BK_VAR;
            BK_VAR:      n_state = BK_SQRT_RMS;
            BK_SQRT_RMS: if (last_sqrt) n_state = BK_SQRT_STD;
            BK_SQRT_STD: if (last_sqrt) n_state = BK_DONE;
            BK_DONE:     if (!r_out_valid || i_ready) n_state = BK_IDLE;
            default:     n_state = BK_IDLE;
        endcase
    end

    // Control outputs.
    always_comb begin
        o_pop    = 1'b0;
        load_out = 1'b0;
        case (r_state)
            BK_IDLE: o_pop    = !i_empty;
            BK_DONE: load_out = !r_out_valid || i_ready;
            default: begin
                o_pop    = 1'b0;
                load_out = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BK_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Datapath.
    always_ff @(posedge i_clk) begin
        case (r_state)
            BK_IDLE: begin
                r_min     <= i_snap.min_v;
                r_max     <= i_snap.max_v;
                r_sum_neg <= i_snap.sum[SUM_W-1];
                r_sum_sq  <= i_snap.sum_sq;
                r_count   <= i_snap.count;
                r_dq      <= SUMSQ_W'(sum_abs);
                r_rem     <= '0;
                r_step    <= '0;
            end
            BK_DIV_MEAN: begin
                r_step <= r_step + STEP_W'(1);
                r_dq   <= n_dq;
                r_rem  <= n_rem;
                if (last_div) begin
                    r_mean_mag <= n_dq[MAG_W-1:0];
                    r_dq       <= r_sum_sq;
                    r_rem      <= '0;
                    r_step     <= '0;
                end
            end
            BK_DIV_MSQ: begin
                r_step <= r_step + STEP_W'(1);
                r_dq   <= n_dq;
                r_rem  <= n_rem;
                if (last_div) begin
                    r_msq <= n_dq[SQ_W-1:0];
                end
            end
            BK_SQUARE: begin
                r_mean_sq <= mean_prod;
            end
            BK_VAR: begin
                r_var    <= (r_msq > r_mean_sq) ? VAR_W'(r_msq - r_mean_sq) : '0;
                r_sq_val <= (2*ROOT_W)'(r_msq);
                r_sq_rem <= '0;
                r_root   <= '0;
                r_step   <= '0;
            end
            BK_SQRT_RMS: begin
                r_step   <= r_step + STEP_W'(1);
                r_sq_val <= {r_sq_val[2*ROOT_W-3:0], 2'b00};
                r_sq_rem <= n_sq_rem;
                r_root   <= n_root;
                if (last_sqrt) begin
                    r_rms    <= n_root;
                    r_sq_val <= (2*ROOT_W)'(r_var);
                    r_sq_rem <= '0;
                    r_root   <= '0;
                    r_step   <= '0;
                end
            end
            BK_SQRT_STD: begin
                r_step   <= r_step + STEP_W'(1);
                r_sq_val <= {r_sq_val[2*ROOT_W-3:0], 2'b00};
                r_sq_rem <= n_sq_rem;
                r_root   <= n_root;
                if (last_sqrt) begin
                    r_std <= n_root;
                end
            end
            default: begin
                r_step <= r_step;
            end
        endcase
        if (load_out) begin
            r_res.min_value   <= r_min;
            r_res.max_value   <= r_max;
            r_res.mean_value  <= mean_signed[PIXEL_BITS-1:0];
            r_res.rms_value   <= r_rms;
            r_res.variance    <= r_var;
            r_res.std_dev     <= r_std;
            r_res.pixel_count <= r_count;
        end
    end

    assign o_result = r_res;
    assign o_valid  = r_out_valid;

endmodule
`default_nettype wire

>>> rtl/image_slice_statistics_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// image_slice_statistics_top
// Running min, max, mean, RMS, variance and standard deviation of one slice.
// ----------------------------------------------------------------------------
// Usage:
// Pixels enter on the slave stream, one beat per pixel, with tlast set on the
// final pixel of a slice. Each slice produces exactly one beat on the master
// stream carrying the slice statistics.
// The accumulator takes one pixel per cycle. It stalls only when the snapshot
// queue between accumulator and math engine is nearly full, which happens
// when slices shorter than the engine time arrive back to back.
// The math engine works through each slice in order: it takes the snapshot
// from the queue, runs the divider twice (mean, then mean of squares), forms
// the squared mean and the variance, runs the square root twice (RMS, then
// standard deviation) and loads the output register. The serial divider
// sets the rate for short slices; long slices are limited only by the one
// pixel per cycle accumulator. Pixels beyond 1048576 in one slice are
// ignored, but their tlast still closes the slice.
// A synchronous active-low reset empties the queue, drops any result and
// returns the accumulators to their empty-slice values.
// If the receiver holds tready low, the result beat waits in the output
// register; the engine can finish the next slice and then waits for it, while
// the queue keeps absorbing pixels and slice snapshots.
// ----------------------------------------------------------------------------
module image_slice_statistics_top (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    // Pixel input.
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    input  wire logic [15:0]  s_axis_tdata,   // [15:0] pixel (signed)
    input  wire logic         s_axis_tlast,   // last_pixel
    // Statistics output.
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    output logic [135:0]      m_axis_tdata    // [15:0] min_value, [31:16] max_value,
                                              // [47:32] mean_value, [63:48] rms_value,
                                              // [94:64] variance, [110:95] std_dev,
                                              // [131:111] pixel_count, rest zero
);
    import isq_pkg::*;

    t_snap              front_snap;
    t_snap              fifo_snap;
    t_fifo_ctrl         fifo_ctrl;
    logic               front_push;
    logic               fifo_empty;
    logic [FIFO_AW:0]   fifo_level;
    logic               back_pop;
    logic               accept;
    t_result            result;

    // One pixel can be in flight in the squaring stage, so keep one slot free.
    assign s_axis_tready = (fifo_level <= (FIFO_AW+1)'(FIFO_DEPTH - 2));
    assign accept        = s_axis_tvalid && s_axis_tready;

    isq_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_pixel  (s_axis_tdata),
        .i_last   (s_axis_tlast),
        .o_push   (front_push),
        .o_snap   (front_snap)
    );

    assign fifo_ctrl.push = front_push;
    assign fifo_ctrl.pop  = back_pop;

    isq_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (fifo_ctrl),
        .i_data  (front_snap),
        .o_data  (fifo_snap),
        .o_empty (fifo_empty),
        .o_level (fifo_level)
    );

    isq_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_snap   (fifo_snap),
        .i_empty  (fifo_empty),
        .o_pop    (back_pop),
        .o_result (result),
        .o_valid  (m_axis_tvalid),
        .i_ready  (m_axis_tready)
    );

    assign m_axis_tdata = {4'b0000, result};

endmodule
`default_nettype wire

>>> tb/sv/image_slice_statistics_top_test.sv
`default_nettype none
// ----------------------------------------------------------------------------
// image_slice_statistics_top_test
// Self-checking bench for the slice statistics block. Pixel slices are
// streamed in with random gaps. A scoreboard class keeps its own running
// min, max, sum, sum of squares and count, and predicts the statistics of
// every closed slice. Each result beat is compared field by field with the
// oldest prediction while the receiver throttles tready at random.
// ----------------------------------------------------------------------------
module image_slice_statistics_top_test;
    import isq_pkg::*;

    // The sender gap and receiver stall sizes below set the slowest run. In
    // the worst case every pixel closes its own slice, and each slice costs
    // the engine time plus the longest gap and stall. The limit is several
    // times that total.
    localparam int  CLK_HALF       = 6;
    localparam int  RANDOM_ITEMS   = 800;
    localparam int  DRAIN_CYCLES   = 400;
    localparam int  DIRECTED_ITEMS = 20;
    localparam time RUN_LIMIT      = 64'd20_000_000;

    // ------------------------------------------------------------------------
    // Scoreboard: predicts slice statistics from the accepted pixel beats and
    // checks each result beat against the oldest prediction.
    // ------------------------------------------------------------------------
    class slice_stats_scoreboard;
        logic signed [PIXEL_BITS-1:0] run_min;
        logic signed [PIXEL_BITS-1:0] run_max;
        logic signed [SUM_W-1:0]      run_sum;
        logic [SUMSQ_W-1:0]           run_sum_sq;
        logic [COUNT_W-1:0]           run_count;
        t_result                      expected_stats_q[$];
        int unsigned                  error_count;

        function new();
            error_count = 0;
            clear_slice();
        endfunction

        function void clear_slice();
            run_min    = PIX_MAX;
            run_max    = PIX_MIN;
            run_sum    = '0;
            run_sum_sq = '0;
            run_count  = '0;
        endfunction

        // Floor square root, built up one result bit at a time.
        function longint unsigned floor_sqrt(longint unsigned v);
            longint unsigned root;
            longint unsigned trial;
            root = 0;
            for (int b = 31; b >= 0; b--) begin
                trial = root | (64'd1 << b);
                if (trial * trial <= v) begin
                    root = trial;
                end
            end
            return root;
        endfunction

        function int pending();
            return expected_stats_q.size();
        endfunction

        function void note_pixel(logic signed [PIXEL_BITS-1:0] px, logic last);
            longint  sq;
            longint  cnt;
            longint  sum64;
            longint  mean;
            longint  msq;
            longint  mean_sq;
            longint  var_v;
            t_result stats;
            // Pixels past the slice limit are dropped, but a last flag on one
            // of them still closes the slice.
            if (run_count < COUNT_LIMIT) begin
                if (px < run_min) begin
                    run_min = px;
                end
                if (px > run_max) begin
                    run_max = px;
                end
                sq         = longint'(px) * longint'(px);
                run_sum    = run_sum + px;
                run_sum_sq = run_sum_sq + SUMSQ_W'(sq);
                run_count  = run_count + 1'b1;
            end
            if (last) begin
                cnt   = longint'(run_count);
                sum64 = run_sum;
                // Signed division truncates toward zero, as the mean requires.
                mean    = sum64 / cnt;
                msq     = longint'(run_sum_sq) / cnt;
                mean_sq = mean * mean;
                var_v   = (msq > mean_sq) ? (msq - mean_sq) : 0;
                stats.min_value   = run_min;
                stats.max_value   = run_max;
                stats.mean_value  = PIXEL_BITS'(mean);
                stats.rms_value   = ROOT_W'(floor_sqrt(msq));
                stats.variance    = VAR_W'(var_v);
                stats.std_dev     = ROOT_W'(floor_sqrt(var_v));
                stats.pixel_count = run_count;
                expected_stats_q.push_back(stats);
                clear_slice();
            end
        endfunction

        task report_mismatch(string what, longint got, longint want);
            error_count++;
            $display("MISMATCH at %0t: %s got %0d expected %0d", $time, what, got, want);
        endtask

        task check_stats_beat(logic [135:0] beat);
            t_result got;
            t_result want;
            if (expected_stats_q.size() == 0) begin
                report_mismatch("result beat with no slice pending", 1, 0);
                return;
            end
            want = expected_stats_q.pop_front();
            got  = beat[131:0];
            if (got.min_value !== want.min_value)
                report_mismatch("min_value", got.min_value, want.min_value);
            if (got.max_value !== want.max_value)
                report_mismatch("max_value", got.max_value, want.max_value);
            if (got.mean_value !== want.mean_value)
                report_mismatch("mean_value", got.mean_value, want.mean_value);
            if (got.rms_value !== want.rms_value)
                report_mismatch("rms_value", got.rms_value, want.rms_value);
            if (got.variance !== want.variance)
                report_mismatch("variance", got.variance, want.variance);
            if (got.std_dev !== want.std_dev)
                report_mismatch("std_dev", got.std_dev, want.std_dev);
            if (got.pixel_count !== want.pixel_count)
                report_mismatch("pixel_count", got.pixel_count, want.pixel_count);
            if (beat[135:132] !== 4'b0)
                report_mismatch("tdata padding", beat[135:132], 0);
        endtask
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset and the signals around the block.
    // ------------------------------------------------------------------------
    logic         i_clk = 1'b0;
    logic         i_rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [15:0]  s_axis_tdata;    // [15:0] pixel (signed)
    logic         s_axis_tlast;    // last_pixel
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [135:0] m_axis_tdata;    // [15:0] min, [31:16] max, [47:32] mean,
                                   // [63:48] rms, [94:64] variance,
                                   // [110:95] std_dev, [131:111] count

    slice_stats_scoreboard stats_board;
    int                    rx_hold = 0;

    always #CLK_HALF i_clk = ~i_clk;

    image_slice_statistics_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // The receiver runs in stretches: mostly ready for a while, sometimes a
    // short stall, rarely a long one. Each stretch length is drawn at random
    // so stalls land on every phase of the engine's work.
    always @(posedge i_clk) begin : rx_pacing
        int pick;
        if (rx_hold > 0) begin
            rx_hold <= rx_hold - 1;
        end else begin
            pick = $urandom_range(0, 19);
            if (pick == 0) begin
                m_axis_tready <= 1'b0;
                rx_hold       <= $urandom_range(20, 80);
            end else if (pick <= 5) begin
                m_axis_tready <= 1'b0;
                rx_hold       <= $urandom_range(0, 3);
            end else begin
                m_axis_tready <= 1'b1;
                rx_hold       <= $urandom_range(0, 30);
            end
        end
    end

    // Every result beat is checked at the edge where it is accepted. Values
    // read here are those from before the edge, on both sides.
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            stats_board.check_stats_beat(m_axis_tdata);
        end
    end

    // ------------------------------------------------------------------------
    // Sender helpers.
    // ------------------------------------------------------------------------

    // Idle cycles before a pixel beat: usually none, often a few, rarely many.
    function automatic int pick_gap();
        int pick;
        pick = $urandom_range(0, 19);
        if (pick == 0) begin
            return $urandom_range(15, 60);
        end else if (pick <= 5) begin
            return $urandom_range(1, 3);
        end
        return 0;
    endfunction

    // Pixel values: the two extremes, small values near zero where the mean
    // and variance are easy to get wrong, and otherwise the full range.
    function automatic logic signed [15:0] pick_pixel();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick == 0) begin
            return PIX_MIN;
        end else if (pick == 1) begin
            return PIX_MAX;
        end else if (pick <= 3) begin
            return 16'($urandom_range(0, 64)) - 16'd32;
        end
        return 16'($urandom);
    endfunction

    // Slice lengths: mostly short, so the engine is often the bottleneck and
    // the snapshot queue fills; some medium and a few long slices.
    function automatic int pick_len();
        int pick;
        pick = $urandom_range(0, 19);
        if (pick == 0) begin
            return $urandom_range(41, 300);
        end else if (pick <= 5) begin
            return $urandom_range(7, 40);
        end
        return $urandom_range(1, 6);
    endfunction

    // Drives one pixel beat and waits for it to be accepted. The task is
    // always entered right after a rising edge. Valid is only lowered when an
    // idle gap follows, so it never gets two updates in one step.
    task automatic send_pixel(logic signed [15:0] px, logic last, int gap);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= px;
        s_axis_tlast  <= last;
        do begin
            @(posedge i_clk);
        end while (!s_axis_tready);
        stats_board.note_pixel(px, last);
    endtask

    // Stops sending until every predicted result has come back.
    task automatic wait_for_results();
        s_axis_tvalid <= 1'b0;
        do begin
            @(posedge i_clk);
        end while (stats_board.pending() != 0);
    endtask

    // ------------------------------------------------------------------------
    // Main sequence.
    // ------------------------------------------------------------------------
    initial begin : stimulus
        logic signed [15:0] dir_px   [DIRECTED_ITEMS];
        bit                 dir_last [DIRECTED_ITEMS];
        int                 sent;
        int                 len;

        stats_board   = new();
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tlast  = 1'b0;

        // Directed slices: single pixels at both extremes and at zero, a
        // full-scale pair whose mean of -1/2 truncates to zero, a negative
        // mean that truncates toward zero, a mixed slice, a constant slice at
        // the top (zero variance) and one at the bottom (RMS of 32768).
        dir_px = '{16'sh7FFF, 16'sh8000, 16'sh0000,
                   16'sh8000, 16'sh7FFF,
                   -16'sd1, -16'sd1, -16'sd2,
                   16'sd5, -16'sd3, 16'sd100, 16'sd0, -16'sd7,
                   16'sh7FFF, 16'sh7FFF, 16'sh7FFF,
                   16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000};
        dir_last = '{1, 1, 1,
                     0, 1,
                     0, 0, 1,
                     0, 0, 0, 0, 1,
                     0, 0, 1,
                     0, 0, 0, 1};

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int k = 0; k < DIRECTED_ITEMS; k++) begin
            send_pixel(dir_px[k], dir_last[k], pick_gap());
        end
        wait_for_results();

        // Random slices with random gaps, with one full pause halfway.
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            len = pick_len();
            for (int k = 0; k < len; k++) begin
                send_pixel(pick_pixel(), k == len - 1, pick_gap());
            end
            if (sent < RANDOM_ITEMS / 2 && sent + len >= RANDOM_ITEMS / 2) begin
                wait_for_results();
            end
            sent += len;
        end
        s_axis_tvalid <= 1'b0;

        // Let every slice come out, then give the block time to show any
        // extra beat it should not produce.
        while (stats_board.pending() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (stats_board.error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    // Guard against a hung handshake.
    initial begin
        #RUN_LIMIT;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
`default_nettype wire
